// ===== src/tlpt_pkg.sv =====
`default_nettype none
package tlpt_pkg;

   localparam int DIR_ENTRIES   = 1024;
   localparam int TABLE_ENTRIES = 1024;
   localparam int TABLE_SLOTS   = 16;

   localparam int DIR_IDX_W = 10;
   localparam int TBL_IDX_W = 10;

   localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;

   localparam logic [1:0] MODE_MAP    = 2'd0;
   localparam logic [1:0] MODE_UNMAP  = 2'd1;
   localparam logic [1:0] MODE_LOOKUP = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_NO_TABLE  = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] virt_addr;
      logic [31:0] phys_addr;
      logic [11:0] entry_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] frame_addr;
   } rsp_type;

endpackage
`default_nettype wire

// ===== src/tlpt_ram.sv =====
`default_nettype none
module tlpt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== src/two_level_page_table_engine.sv =====
`default_nettype none
// Two-level page table engine. After reset the block runs a clearing pass over
// the table store (and the directory alongside it), with busy high. It then
// accepts one item on a cycle where start is high and busy is low. Map, unmap,
// any other mode and a lookup that finds no second-level table give their result
// strobe once the registered directory read is in; a lookup whose table is
// present gives it only after a further registered read of the table store.
// This is because the directory and the table store are single-port memories
// with registered reads and the table access can only follow the directory
// read. busy drops in the cycle the result is strobed, so a new item can be
// taken in that same cycle, but none before the last item is through.
// The result is shown for one cycle on rsp_strobe and cannot be held off.
module two_level_page_table_engine #(
   parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tlpt_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output tlpt_pkg::rsp_type     rsp_data
);

   localparam int TAG_W     = $clog2(TABLE_SLOTS + 1);
   localparam int TBL_DEPTH = TABLE_SLOTS * tlpt_pkg::TABLE_ENTRIES;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int DIR_AW    = tlpt_pkg::DIR_IDX_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIR,
      ST_TBL
   } state_type;

   state_type             state_ff, state_in;
   logic [TBL_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [TAG_W-1:0]      next_free_ff, next_free_in;
   tlpt_pkg::req_type     req_ff, req_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   tlpt_pkg::rsp_type     rsp_ff, rsp_in;

   logic                  dir_we;
   logic [DIR_AW-1:0]     dir_addr;
   logic [TAG_W-1:0]      dir_wdata;
   logic [TAG_W-1:0]      dir_rdata;
   logic                  tbl_we;
   logic [TBL_AW-1:0]     tbl_addr;
   logic [31:0]           tbl_wdata;
   logic [31:0]           tbl_rdata;

   logic                  present;
   logic                  exhausted;
   logic [TAG_W-1:0]      slot_sel;
   logic [TAG_W-1:0]      tag_next;
   logic                  accept;

   assign accept    = start && !busy;
   assign present   = dir_rdata != '0;
   assign exhausted = next_free_ff == TAG_W'(TABLE_SLOTS);
   assign tag_next  = next_free_ff + TAG_W'(1);
   assign slot_sel  = present ? (dir_rdata - TAG_W'(1)) : next_free_ff;

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      next_free_in  = next_free_ff;
      req_in        = req_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      dir_we        = 1'b0;
      dir_addr      = req_ff.virt_addr[31:22];
      dir_wdata     = tag_next;
      tbl_we        = 1'b0;
      tbl_addr      = TBL_AW'({slot_sel, req_ff.virt_addr[21:12]});
      tbl_wdata     = '0;
      case (state_ff)
         ST_CLEAR: begin
            dir_addr  = clr_cnt_ff[DIR_AW-1:0];
            dir_wdata = '0;
            dir_we    = (clr_cnt_ff >> DIR_AW) == '0;
            tbl_addr  = clr_cnt_ff;
            tbl_we    = 1'b1;
            clr_cnt_in = clr_cnt_ff + TBL_AW'(1);
            if (clr_cnt_ff == TBL_AW'(TBL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            dir_addr = req_data.virt_addr[31:22];
            if (start) begin
               req_in   = req_data;
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            rsp_in.status     = tlpt_pkg::STATUS_DONE;
            rsp_in.found      = 1'b0;
            rsp_in.frame_addr = '0;
            rsp_strobe_in     = 1'b1;
            state_in          = ST_IDLE;
            case (req_ff.mode)
               tlpt_pkg::MODE_MAP: begin
                  if (!present && exhausted) begin
                     rsp_in.status = tlpt_pkg::STATUS_EXHAUSTED;
                  end else begin
                     tbl_we    = 1'b1;
                     tbl_wdata = (req_ff.phys_addr & tlpt_pkg::FRAME_MASK)
                               | {20'd0, req_ff.entry_flags};
                     if (!present) begin
                        dir_we       = 1'b1;
                        next_free_in = tag_next;
                     end
                  end
               end
               tlpt_pkg::MODE_UNMAP: begin
                  if (present) begin
                     tbl_we = 1'b1;
                  end else begin
                     rsp_in.status = tlpt_pkg::STATUS_NO_TABLE;
                  end
               end
               tlpt_pkg::MODE_LOOKUP: begin
                  if (present) begin
                     rsp_strobe_in = 1'b0;
                     state_in      = ST_TBL;
                  end else begin
                     rsp_in.status = tlpt_pkg::STATUS_NO_TABLE;
                  end
               end
               default: begin
                  rsp_in.status = tlpt_pkg::STATUS_DONE;
               end
            endcase
         end
         ST_TBL: begin
            rsp_in.status     = tlpt_pkg::STATUS_DONE;
            rsp_in.found      = tbl_rdata != '0;
            rsp_in.frame_addr = tbl_rdata & tlpt_pkg::FRAME_MASK;
            rsp_strobe_in     = 1'b1;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         next_free_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         next_free_ff  <= next_free_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   tlpt_ram #(
      .WIDTH(TAG_W),
      .DEPTH(tlpt_pkg::DIR_ENTRIES)
   ) u_dir_ram (
      .clock(clock),
      .we   (dir_we),
      .addr (dir_addr),
      .wdata(dir_wdata),
      .rdata(dir_rdata)
   );

   tlpt_ram #(
      .WIDTH(32),
      .DEPTH(TBL_DEPTH)
   ) u_tbl_ram (
      .clock(clock),
      .we   (tbl_we),
      .addr (tbl_addr),
      .wdata(tbl_wdata),
      .rdata(tbl_rdata)
   );

   a_strobe_after_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_DIR || $past(state_ff) == ST_TBL))
      else $error("result strobe without a walk step");

   a_slot_count_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= TAG_W'(TABLE_SLOTS))
      else $error("slot count beyond table slots");

   a_alloc_is_map: assert property (@(posedge clock) disable iff (reset)
      (dir_we && state_ff == ST_DIR) |-> (req_ff.mode == tlpt_pkg::MODE_MAP && tbl_we))
      else $error("directory write outside a map");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after item accepted");

endmodule
`default_nettype wire

// ===== verif/page_table_checker.sv =====
module page_table_checker
   import tlpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      open_count,
   output int      checked_count,
   output int      hit_count,
   output int      exhausted_count,
   output int      no_table_count
);

   // 0 means no table, k means slot k-1
   logic [4:0]  dir_tag [DIR_ENTRIES];
   logic [31:0] page_entry [TABLE_SLOTS * TABLE_ENTRIES];
   int          slots_used = 0;
   rsp_type     expected_rsp [$];
   int          errors = 0;
   int          checked = 0;
   int          hits = 0;
   int          exhausted = 0;
   int          no_table = 0;

   function automatic rsp_type walk_page_table(input req_type item);
      logic [9:0] dir_idx;
      logic [9:0] tbl_idx;
      logic       present;
      int         pos;
      rsp_type    result;
      dir_idx = item.virt_addr[31:22];
      tbl_idx = item.virt_addr[21:12];
      present = dir_tag[dir_idx] != 5'd0 && dir_tag[dir_idx] <= TABLE_SLOTS;
      pos = present ? (int'(dir_tag[dir_idx]) - 1) * TABLE_ENTRIES + int'(tbl_idx) : 0;
      result = '0;
      case (item.mode)
         MODE_MAP: begin
            if (!present) begin
               if (slots_used >= TABLE_SLOTS) begin
                  result.status = STATUS_EXHAUSTED;
               end else begin
                  dir_tag[dir_idx] = 5'(slots_used + 1);
                  for (int i = 0; i < TABLE_ENTRIES; i++)
                     page_entry[slots_used * TABLE_ENTRIES + i] = '0;
                  pos = slots_used * TABLE_ENTRIES + int'(tbl_idx);
                  slots_used++;
                  present = 1'b1;
               end
            end
            if (present)
               page_entry[pos] = (item.phys_addr & FRAME_MASK) | {20'd0, item.entry_flags};
         end
         MODE_UNMAP: begin
            if (present)
               page_entry[pos] = '0;
            else
               result.status = STATUS_NO_TABLE;
         end
         MODE_LOOKUP: begin
            if (!present) begin
               result.status = STATUS_NO_TABLE;
            end else if (page_entry[pos] != '0) begin
               result.found      = 1'b1;
               result.frame_addr = page_entry[pos] & FRAME_MASK;
            end
         end
         default: ;
      endcase
      return result;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < DIR_ENTRIES; i++)
            dir_tag[i] = '0;
         for (int i = 0; i < TABLE_SLOTS * TABLE_ENTRIES; i++)
            page_entry[i] = '0;
         slots_used = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: status %0d found %0d frame %h",
                           rsp_data.status, rsp_data.found, rsp_data.frame_addr);
            end else begin
               want = expected_rsp.pop_front();
               checked++;
               if (want.found)
                  hits++;
               if (want.status == STATUS_EXHAUSTED)
                  exhausted++;
               if (want.status == STATUS_NO_TABLE)
                  no_table++;
               if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                   rsp_data.frame_addr !== want.frame_addr) begin
                  errors++;
                  if (errors <= 10)
                     $display("result %0d: want status %0d found %0d frame %h, got %0d %0d %h",
                              checked, want.status, want.found, want.frame_addr,
                              rsp_data.status, rsp_data.found, rsp_data.frame_addr);
               end
            end
         end
         if (start && !busy)
            expected_rsp.push_back(walk_page_table(req_data));
      end
      fail_count      <= errors;
      open_count      <= expected_rsp.size();
      checked_count   <= checked;
      hit_count       <= hits;
      exhausted_count <= exhausted;
      no_table_count  <= no_table;
   end

endmodule

// ===== verif/tb_two_level_page_table_engine.sv =====
module tb_two_level_page_table_engine;
   import tlpt_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_LIMIT   = 60000;
   localparam int PHASE_ITEMS   = 630;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int fail_count;
   int open_count;
   int checked_count;
   int hit_count;
   int exhausted_count;
   int no_table_count;
   int stall_cycles = 0;
   int sender_idle_pct = 0;

   logic [9:0] dir_pool [20];
   logic [9:0] tbl_pool [8];

   always #10 clock = ~clock;

   two_level_page_table_engine dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   page_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_data        (rsp_data),
      .fail_count      (fail_count),
      .open_count      (open_count),
      .checked_count   (checked_count),
      .hit_count       (hit_count),
      .exhausted_count (exhausted_count),
      .no_table_count  (no_table_count)
   );

   // watchdog, allows for the clearing pass after reset
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [31:0] page_va(input logic [9:0] dir_idx, input logic [9:0] tbl_idx);
      return {dir_idx, tbl_idx, 12'h000};
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [31:0] va,
                            input logic [31:0] pa, input logic [11:0] flags);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_data <= '{mode: op, virt_addr: va, phys_addr: pa, entry_flags: flags};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random();
      logic [1:0]  op;
      logic [31:0] va;
      logic [31:0] pa;
      logic [11:0] flags;
      logic [9:0]  tbl_idx;
      int          pick;
      pick  = $urandom_range(99);
      pa    = $urandom();
      flags = 12'($urandom());
      if (pick < 10) begin
         // noise: any address, never allocates a table
         op = 2'($urandom_range(1, 3));
         va = $urandom();
      end else begin
         op = pick < 48 ? MODE_MAP : (pick < 62 ? MODE_UNMAP : MODE_LOOKUP);
         tbl_idx = ($urandom_range(3) == 0) ? 10'($urandom()) : tbl_pool[$urandom_range(7)];
         va = {dir_pool[$urandom_range(19)], tbl_idx, 12'($urandom())};
         if ($urandom_range(19) == 0) begin
            pa    = '0;
            flags = '0;
         end
      end
      send_item(op, va, pa, flags);
   endtask

   initial begin
      dir_pool[0] = 10'h000;
      dir_pool[1] = 10'h3FF;
      for (int i = 2; i < 20; i++)
         dir_pool[i] = 10'($urandom());
      tbl_pool[0] = 10'h000;
      tbl_pool[1] = 10'h3FF;
      for (int i = 2; i < 8; i++)
         tbl_pool[i] = 10'($urandom());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_item(MODE_LOOKUP, page_va(10'h000, 10'h000), '0, '0);
      send_item(MODE_UNMAP, page_va(10'h000, 10'h000), '0, '0);
      send_item(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      send_item(MODE_MAP, page_va(10'h000, 10'h000), 32'hFFFF_FFFF, 12'hFFF);
      send_item(MODE_LOOKUP, 32'h0000_0FFF, '0, '0);
      send_item(MODE_MAP, page_va(10'h000, 10'h3FF), '0, '0);
      send_item(MODE_LOOKUP, page_va(10'h000, 10'h3FF), '0, '0);
      send_item(MODE_MAP, page_va(10'h3FF, 10'h3FF), '0, 12'hFFF);
      send_item(MODE_LOOKUP, 32'hFFFF_FFFF, '0, '0);
      send_item(MODE_UNMAP, page_va(10'h3FF, 10'h3FF), '0, '0);
      send_item(MODE_LOOKUP, page_va(10'h3FF, 10'h3FF), '0, '0);
      send_item(MODE_LOOKUP, page_va(10'h000, 10'h005), '0, '0);
      send_item(MODE_MAP, page_va(10'h3FF, 10'h000), 32'h1234_5678, '0);
      send_item(MODE_LOOKUP, page_va(10'h3FF, 10'h000), '0, '0);
      send_item(MODE_UNMAP, page_va(10'h000, 10'h3FF), '0, '0);
      send_item(MODE_UNUSED, '0, '0, '0);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 23 : ((phase == 1) ? 68 : 0);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random();
      end
      start <= 1'b0;

      @(posedge clock);
      while (open_count != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d results: %0d lookup hits, %0d maps with slots exhausted,",
               checked_count, hit_count, exhausted_count);
      $display("%0d items without a table, under three sender idle rates", no_table_count);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/tlpt_pkg.sv
src/tlpt_ram.sv
src/two_level_page_table_engine.sv
verif/page_table_checker.sv
verif/tb_two_level_page_table_engine.sv
